// ===== sv/gdcc_pkg.sv =====
// Package with the shared types, constants and rounding helpers of the gated convolution block.
`timescale 1ns / 1ps

package gdcc_pkg;

  localparam int unsigned DATA_W      = 16;
  localparam int unsigned CH_FIELD_W  = 10;
  localparam int unsigned TAP_FIELD_W = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned TAPS_CFG_W  = 3;
  localparam int unsigned PROD_W      = 32;
  localparam int unsigned ACC_W       = 40;
  localparam int unsigned RND_W       = 48;

  localparam logic [CFG_IDX_W-1:0]  REG_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_TAPS     = 2'd1;
  localparam logic [CFG_DATA_W-1:0] CHANNELS_RST = 11'd1024;
  localparam logic [TAPS_CFG_W-1:0] TAPS_RST     = 3'd3;

  localparam logic KIND_WEIGHT = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam int unsigned GATE_SHIFT = 12;
  localparam int unsigned TAP_SHIFT  = 14;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GATE,
    ST_STORE,
    ST_TAPS,
    ST_DRAIN,
    ST_SCALE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     clip;
  } rsat_t;

  // Rounds half toward plus infinity after a right shift, then saturates to 16 bits.
  function automatic rsat_t round_sat(input logic signed [RND_W-1:0] v,
                                      input int unsigned sh);
    logic signed [RND_W-1:0] r;
    rsat_t res;
    r = (v + (RND_W'(48'sd1) <<< (sh - 1))) >>> sh;
    if (r > 48'sd32767) begin
      res.val  = 16'sh7fff;
      res.clip = 1'b1;
    end else if (r < -48'sd32768) begin
      res.val  = 16'sh8000;
      res.clip = 1'b1;
    end else begin
      res.val  = r[DATA_W-1:0];
      res.clip = 1'b0;
    end
    return res;
  endfunction

  // Remainder of a small slot value by a tap count of at least one.
  function automatic logic [TAPS_CFG_W-1:0] slot_mod(input logic [TAPS_CFG_W-1:0] a,
                                                     input logic [TAPS_CFG_W-1:0] m);
    logic [TAPS_CFG_W-1:0] r;
    r = a;
    for (int i = 0; i < 6; i++) begin
      if (r >= m) begin
        r = r - m;
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/gdcc_ram.sv =====
// Simple dual-port memory with one write port and one registered read port.
`timescale 1ns / 1ps

module gdcc_ram #(
  parameter int unsigned DW = 16,
  parameter int unsigned AW = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/gated_depthwise_causal_conv.sv =====
// Gated depthwise causal convolution: sequencer, arithmetic and history and weight memories.
// A sample transaction passes gate multiply, history write, one read per tap, drain, scale
// and the load into the result register in that order, and input is taken again after the
// load, which waits while a result is stalled; a weight is written in its acceptance cycle.
// After reset a clearing pass writes zero to every history entry, one per cycle, all
// 2**(clog2(MAX_CHANNELS)+clog2(MAX_TAPS)) of them (4096 by default), before input is taken.
`timescale 1ns / 1ps

module gated_depthwise_causal_conv #(
  parameter int unsigned MAX_CHANNELS = 1024,
  parameter int unsigned MAX_TAPS     = 4
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [gdcc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [gdcc_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   kind_i,
  input  logic [gdcc_pkg::CH_FIELD_W-1:0]        weight_channel_i,
  input  logic [gdcc_pkg::TAP_FIELD_W-1:0]       weight_tap_i,
  input  logic signed [gdcc_pkg::DATA_W-1:0]     weight_value_i,
  input  logic signed [gdcc_pkg::DATA_W-1:0]     gate_b_i,
  input  logic signed [gdcc_pkg::DATA_W-1:0]     gate_c_i,
  input  logic signed [gdcc_pkg::DATA_W-1:0]     x_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [gdcc_pkg::DATA_W-1:0]     y_value_o,
  output logic [gdcc_pkg::CH_FIELD_W-1:0]        out_channel_o,
  output logic                                   step_end_o,
  output logic                                   saturated_o
);

  import gdcc_pkg::*;

  localparam int unsigned CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned TW = $clog2(MAX_TAPS);
  localparam int unsigned AW = CW + TW;

  state_e state_q, state_d;

  logic [CFG_DATA_W-1:0] chans_q;
  logic [TAPS_CFG_W-1:0] taps_q;
  logic [TAPS_CFG_W-1:0] ws_q, ws_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         clr_addr_q;
  logic [TAPS_CFG_W-1:0] k_q;
  logic                  rd_v_q, pm_v_q;
  logic                  out_valid_q;

  logic [CW-1:0]            ch_q;
  logic [TAPS_CFG_W-1:0]    slot_q, teff_q;
  logic                     last_q;
  logic signed [DATA_W-1:0] gb_q, gc_q, x_q;
  logic signed [PROD_W-1:0] prod_q, pm_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     clip_q;
  logic signed [DATA_W-1:0] y_q;
  logic [CH_FIELD_W-1:0]    och_q;
  logic                     end_q, sat_q;

  logic [TAPS_CFG_W-1:0] teff_now, slot_now, slot_next;
  logic                  last_now;
  logic                  accept_sample, accept_weight, weight_in_range, out_free, out_load;
  logic [TAPS_CFG_W:0]   idx_sum;
  logic [TAPS_CFG_W-1:0] idx;

  logic          hist_we, w_we;
  logic [AW-1:0] hist_waddr, hist_raddr, w_waddr, w_raddr;
  logic [DATA_W-1:0] hist_wdata, hist_rdata, w_rdata;

  rsat_t bx_r, conv_r, y_r;
  logic signed [DATA_W-1:0] conv_val;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);

  always_comb begin
    if (taps_q == '0) begin
      teff_now = TAPS_CFG_W'(1);
    end else if (32'(taps_q) > MAX_TAPS) begin
      teff_now = TAPS_CFG_W'(MAX_TAPS);
    end else begin
      teff_now = taps_q;
    end
    slot_now  = slot_mod(ws_q, teff_now);
    slot_next = (slot_now + TAPS_CFG_W'(1) == teff_now) ? '0 : slot_now + TAPS_CFG_W'(1);
    last_now  = (32'(cnt_q) + 32'd1 >= 32'(chans_q)) ||
                (32'(cnt_q) + 32'd1 >= MAX_CHANNELS);
  end

  assign accept_sample   = in_valid_i && in_ready_o && (kind_i == KIND_SAMPLE);
  assign accept_weight   = in_valid_i && in_ready_o && (kind_i == KIND_WEIGHT);
  assign weight_in_range = (32'(weight_channel_i) < MAX_CHANNELS) &&
                           (32'(weight_tap_i) < MAX_TAPS);
  assign out_free        = !out_valid_q || out_ready_i;
  assign out_load        = (state_q == ST_OUT) && out_free;

  assign idx_sum = {1'b0, slot_q} + (TAPS_CFG_W + 1)'(1) + {1'b0, k_q};
  assign idx     = (idx_sum >= {1'b0, teff_q}) ? TAPS_CFG_W'(idx_sum - {1'b0, teff_q})
                                               : TAPS_CFG_W'(idx_sum);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept_sample) begin
          state_d = ST_GATE;
        end
      end
      ST_GATE:  state_d = ST_STORE;
      ST_STORE: state_d = ST_TAPS;
      ST_TAPS: begin
        if (k_q == teff_q - TAPS_CFG_W'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_q && !pm_v_q) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = {ch_q, TW'(slot_q)};
    hist_wdata = bx_r.val;
    hist_raddr = {ch_q, TW'(idx)};
    w_we       = 1'b0;
    w_waddr    = {CW'(weight_channel_i), TW'(weight_tap_i)};
    w_raddr    = {ch_q, TW'(k_q)};
    cnt_d      = cnt_q;
    ws_d       = ws_q;
    case (state_q)
      ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_addr_q;
        hist_wdata = '0;
      end
      ST_IDLE: begin
        w_we = accept_weight && weight_in_range;
        if (accept_sample) begin
          cnt_d = last_now ? '0 : cnt_q + CW'(1);
          ws_d  = last_now ? slot_next : ws_q;
        end
      end
      ST_STORE: hist_we = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      chans_q     <= CHANNELS_RST;
      taps_q      <= TAPS_RST;
      ws_q        <= '0;
      cnt_q       <= '0;
      clr_addr_q  <= '0;
      k_q         <= '0;
      rd_v_q      <= 1'b0;
      pm_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ws_q    <= ws_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_CHANNELS) begin
          chans_q <= cfg_data_i;
        end else if (cfg_index_i == REG_TAPS) begin
          taps_q <= cfg_data_i[TAPS_CFG_W-1:0];
        end
      end
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (state_q == ST_STORE) begin
        k_q <= '0;
      end else if (state_q == ST_TAPS) begin
        k_q <= k_q + TAPS_CFG_W'(1);
      end
      rd_v_q <= (state_q == ST_TAPS);
      pm_v_q <= rd_v_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign bx_r     = round_sat(RND_W'(prod_q), GATE_SHIFT);
  assign conv_r   = round_sat(RND_W'(acc_q), TAP_SHIFT);
  assign conv_val = conv_r.val;
  assign y_r      = round_sat(RND_W'(prod_q), GATE_SHIFT);

  always_ff @(posedge clk_i) begin
    if (accept_sample) begin
      gb_q   <= gate_b_i;
      gc_q   <= gate_c_i;
      x_q    <= x_value_i;
      ch_q   <= cnt_q;
      slot_q <= slot_now;
      teff_q <= teff_now;
      last_q <= last_now;
    end
    if (state_q == ST_GATE) begin
      prod_q <= gb_q * x_q;
    end else if (state_q == ST_SCALE) begin
      prod_q <= gc_q * conv_val;
    end
    if (state_q == ST_STORE) begin
      clip_q <= bx_r.clip;
    end else if (state_q == ST_SCALE) begin
      clip_q <= clip_q | conv_r.clip;
    end
    pm_q <= $signed(hist_rdata) * $signed(w_rdata);
    if (state_q == ST_STORE) begin
      acc_q <= '0;
    end else if (pm_v_q) begin
      acc_q <= acc_q + ACC_W'(pm_q);
    end
    if (out_load) begin
      y_q   <= y_r.val;
      och_q <= CH_FIELD_W'(ch_q);
      end_q <= last_q;
      sat_q <= clip_q | y_r.clip;
    end
  end

  gdcc_ram #(
    .DW(DATA_W),
    .AW(AW)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(hist_waddr),
    .wdata_i(hist_wdata),
    .raddr_i(hist_raddr),
    .rdata_o(hist_rdata)
  );

  gdcc_ram #(
    .DW(DATA_W),
    .AW(AW)
  ) u_weight_ram (
    .clk_i  (clk_i),
    .we_i   (w_we),
    .waddr_i(w_waddr),
    .wdata_i(weight_value_i),
    .raddr_i(w_raddr),
    .rdata_o(w_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign y_value_o     = y_q;
  assign out_channel_o = och_q;
  assign step_end_o    = end_q;
  assign saturated_o   = sat_q;

endmodule

// ===== sv/gdcc_checker.sv =====
// Port-level checker for the gated convolution block and the bind that attaches it.
`timescale 1ns / 1ps

module gdcc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               kind_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [gdcc_pkg::DATA_W-1:0] y_value_o,
  input logic [gdcc_pkg::CH_FIELD_W-1:0]    out_channel_o,
  input logic                               step_end_o,
  input logic                               saturated_o
);

  import gdcc_pkg::*;

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(y_value_o) &&
      $stable(out_channel_o) && $stable(step_end_o) && $stable(saturated_o))
    else $error("result changed while stalled");

  // A weight transaction leaves the block ready in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == KIND_WEIGHT) |=> in_ready_o)
    else $error("weight write did not return to ready");

  // A sample transaction makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == KIND_SAMPLE) |=> !in_ready_o)
    else $error("sample did not start processing");

  // A new result only appears when the block was busy just before it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without processing");

endmodule

bind gated_depthwise_causal_conv gdcc_checker u_gdcc_checker (.*);

// ===== test/gated_depthwise_causal_conv_test.sv =====
// Self-checking testbench for the gated depthwise causal convolution block.
`timescale 1ns / 1ps

module gated_depthwise_causal_conv_test;
  import gdcc_pkg::*;

  localparam int unsigned CHANS_MAX   = 1024;
  localparam int unsigned TAPS_MAX    = 4;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 12;
  localparam int unsigned PHASES      = 12;

  typedef struct packed {
    logic                     kind;
    logic [CH_FIELD_W-1:0]    wch;
    logic [TAP_FIELD_W-1:0]   wtap;
    logic signed [DATA_W-1:0] wval;
    logic signed [DATA_W-1:0] gb;
    logic signed [DATA_W-1:0] gc;
    logic signed [DATA_W-1:0] x;
    logic                     known;
    logic signed [DATA_W-1:0] y_fix;
    logic                     sat_fix;
  } stim_row_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] y;
    logic [CH_FIELD_W-1:0]    ch;
    logic                     step_end;
    logic                     sat;
  } conv_out_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic kind_i;
  logic [CH_FIELD_W-1:0] weight_channel_i;
  logic [TAP_FIELD_W-1:0] weight_tap_i;
  logic signed [DATA_W-1:0] weight_value_i;
  logic signed [DATA_W-1:0] gate_b_i;
  logic signed [DATA_W-1:0] gate_c_i;
  logic signed [DATA_W-1:0] x_value_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [DATA_W-1:0] y_value_o;
  logic [CH_FIELD_W-1:0] out_channel_o;
  logic step_end_o;
  logic saturated_o;

  logic signed [DATA_W-1:0] hist_mem [CHANS_MAX][TAPS_MAX];
  logic signed [DATA_W-1:0] wgt_mem [CHANS_MAX][TAPS_MAX];
  bit wgt_set [CHANS_MAX][TAPS_MAX];
  logic [CFG_DATA_W-1:0] cfg_chans;
  logic [TAPS_CFG_W-1:0] cfg_taps;
  int unsigned chan_q;
  int unsigned slot_q;

  conv_out_t due_outputs [$];
  conv_out_t want;
  stim_row_t dir_rows [23];

  bit calm;
  bit hold_go;
  int unsigned fail_count;
  int unsigned results_seen;
  int unsigned sat_seen;
  int unsigned ends_seen;
  int unsigned samples_sent;
  int unsigned weights_sent;
  int unsigned settings_used;

  gated_depthwise_causal_conv #(
    .MAX_CHANNELS(CHANS_MAX),
    .MAX_TAPS(TAPS_MAX)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .kind_i(kind_i),
    .weight_channel_i(weight_channel_i),
    .weight_tap_i(weight_tap_i),
    .weight_value_i(weight_value_i),
    .gate_b_i(gate_b_i),
    .gate_c_i(gate_c_i),
    .x_value_i(x_value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .y_value_o(y_value_o),
    .out_channel_o(out_channel_o),
    .step_end_o(step_end_o),
    .saturated_o(saturated_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned chans_now();
    if (cfg_chans == '0) return 1;
    if (int'(cfg_chans) > CHANS_MAX) return CHANS_MAX;
    return int'(cfg_chans);
  endfunction

  function automatic int unsigned taps_now();
    if (cfg_taps == '0) return 1;
    if (int'(cfg_taps) > TAPS_MAX) return TAPS_MAX;
    return int'(cfg_taps);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_round(input longint v, input int sh,
                                                         inout bit clip);
    longint q;
    q = (v + (longint'(1) <<< (sh - 1))) >>> sh;
    if (q > 32767) begin
      clip = 1'b1;
      return 16'sh7fff;
    end
    if (q < -32768) begin
      clip = 1'b1;
      return 16'sh8000;
    end
    return q[DATA_W-1:0];
  endfunction

  function automatic bit gated_conv_step(input stim_row_t r, output conv_out_t res);
    int unsigned n_ch;
    int unsigned n_tap;
    int unsigned slot;
    bit clip;
    longint acc;
    logic signed [DATA_W-1:0] conv;
    res = '0;
    if (r.kind == KIND_WEIGHT) begin
      wgt_mem[r.wch][r.wtap] = r.wval;
      wgt_set[r.wch][r.wtap] = 1'b1;
      return 1'b0;
    end
    n_ch = chans_now();
    n_tap = taps_now();
    slot = slot_q % n_tap;
    clip = 1'b0;
    hist_mem[chan_q][slot] = sat_round(longint'(r.gb) * longint'(r.x), GATE_SHIFT, clip);
    acc = 0;
    for (int unsigned k = 0; k < n_tap; k++) begin
      acc += longint'(hist_mem[chan_q][(slot + 1 + k) % n_tap]) * longint'(wgt_mem[chan_q][k]);
    end
    conv = sat_round(acc, TAP_SHIFT, clip);
    res.y = sat_round(longint'(r.gc) * longint'(conv), GATE_SHIFT, clip);
    res.ch = CH_FIELD_W'(chan_q);
    res.step_end = (chan_q + 1 >= n_ch);
    res.sat = clip;
    if (res.step_end) begin
      chan_q = 0;
      slot_q = (slot + 1) % n_tap;
    end else begin
      chan_q++;
    end
    return 1'b1;
  endfunction

  function automatic stim_row_t weight_row(input int ch, input int tap, input int val);
    stim_row_t r;
    r = '0;
    r.kind = KIND_WEIGHT;
    r.wch = CH_FIELD_W'(ch);
    r.wtap = TAP_FIELD_W'(tap);
    r.wval = DATA_W'(val);
    return r;
  endfunction

  function automatic stim_row_t sample_row(input int gb, input int x, input int gc,
                                           input bit known, input int y, input bit sat);
    stim_row_t r;
    r = '0;
    r.kind = KIND_SAMPLE;
    r.gb = DATA_W'(gb);
    r.x = DATA_W'(x);
    r.gc = DATA_W'(gc);
    r.known = known;
    r.y_fix = DATA_W'(y);
    r.sat_fix = sat;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic send_item(input stim_row_t r);
    conv_out_t res;
    if (!calm && $urandom_range(99) < 11) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat ($urandom_range(5)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    kind_i <= r.kind;
    weight_channel_i <= r.wch;
    weight_tap_i <= r.wtap;
    weight_value_i <= r.wval;
    gate_b_i <= r.gb;
    gate_c_i <= r.gc;
    x_value_i <= r.x;
    do @(posedge clk_i); while (!in_ready_o);
    if (gated_conv_step(r, res)) begin
      samples_sent++;
      if (r.known) begin
        res.y = r.y_fix;
        res.sat = r.sat_fix;
      end
      due_outputs.push_back(res);
    end else begin
      weights_sent++;
    end
  endtask

  // A sample never reads a tap weight that was not written, so missing ones go first.
  task automatic offer_item(input stim_row_t r);
    if (r.kind == KIND_SAMPLE) begin
      for (int unsigned k = 0; k < taps_now(); k++) begin
        if (!wgt_set[chan_q][k]) send_item(weight_row(int'(chan_q), int'(k), int'($urandom)));
      end
    end
    send_item(r);
  endtask

  task automatic wait_for_results();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_CHANNELS) cfg_chans = CFG_DATA_W'(val);
    else cfg_taps = TAPS_CFG_W'(val);
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (saturated_o) sat_seen++;
      if (step_end_o) ends_seen++;
      if (due_outputs.size() == 0) begin
        flag_mismatch($sformatf("result for channel %0d with nothing expected", out_channel_o));
      end else begin
        want = due_outputs.pop_front();
        if (y_value_o !== want.y)
          flag_mismatch($sformatf("channel %0d y_value %0d, expected %0d", want.ch,
                                  $signed(y_value_o), $signed(want.y)));
        if (out_channel_o !== want.ch)
          flag_mismatch($sformatf("out_channel %0d, expected %0d", out_channel_o, want.ch));
        if (step_end_o !== want.step_end)
          flag_mismatch($sformatf("channel %0d step_end %b, expected %b", want.ch,
                                  step_end_o, want.step_end));
        if (saturated_o !== want.sat)
          flag_mismatch($sformatf("channel %0d saturated %b, expected %b", want.ch,
                                  saturated_o, want.sat));
      end
    end
  end

  initial begin
    bit held;
    held = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_ready_i <= calm || ($urandom_range(99) >= 11);
    end
  end

  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("No transaction for %0d cycles.", STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    stim_row_t r;
    int unsigned n_items;
    int unsigned n_ch;
    int unsigned phase_chans [PHASES];
    int unsigned phase_taps [PHASES];
    phase_chans = '{1, 0, 2047, 3, 8, 1024, 5, 2, 16, 7, 4, 1};
    phase_taps = '{1, 0, 1, 7, 4, 1, 2, 5, 3, 6, 4, 2};
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    kind_i = KIND_WEIGHT;
    weight_channel_i = '0;
    weight_tap_i = '0;
    weight_value_i = '0;
    gate_b_i = '0;
    gate_c_i = '0;
    x_value_i = '0;
    calm = 1'b0;
    hold_go = 1'b0;
    foreach (hist_mem[c, t]) begin
      hist_mem[c][t] = '0;
      wgt_mem[c][t] = '0;
      wgt_set[c][t] = 1'b0;
    end
    cfg_chans = CHANNELS_RST;
    cfg_taps = TAPS_RST;
    chan_q = 0;
    slot_q = 0;

    // With a fresh history only the newest entry counts, and it pairs with the last tap.
    dir_rows = '{
      weight_row(0, 0, -32768), weight_row(0, 1, 32767), weight_row(0, 2, 16384),
      sample_row(4096, 4096, 4096, 1'b1, 4096, 1'b0),
      weight_row(1, 2, 16384),
      sample_row(0, -32768, -32768, 1'b1, 0, 1'b0),
      weight_row(2, 2, 16384),
      sample_row(32767, 32767, 4096, 1'b1, 32767, 1'b1),
      weight_row(3, 2, 16384),
      sample_row(-32768, -32768, -32768, 1'b1, -32768, 1'b1),
      weight_row(4, 2, 16384),
      sample_row(-32768, 32767, 32767, 1'b1, -32768, 1'b1),
      weight_row(5, 2, 16384),
      sample_row(1, 2048, 4096, 1'b1, 1, 1'b0),
      weight_row(6, 2, 16384),
      sample_row(-1, 2048, 4096, 1'b1, 0, 1'b0),
      weight_row(7, 2, -32768),
      sample_row(4096, 20000, 4096, 1'b1, -32768, 1'b1),
      weight_row(8, 2, 16384),
      sample_row(4096, 4096, 32767, 1'b1, 32767, 1'b0),
      weight_row(1023, 3, -1),
      sample_row(12345, -999, 777, 1'b0, 0, 1'b0),
      weight_row(9, 0, -20000)
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (dir_rows[i]) offer_item(dir_rows[i]);

    for (int p = 0; p <= PHASES; p++) begin
      if (p > 0) begin
        wait_for_results();
        if (p % 2 == 1) begin
          write_reg(REG_TAPS, phase_taps[p-1]);
          write_reg(REG_CHANNELS, phase_chans[p-1]);
        end else begin
          write_reg(REG_CHANNELS, phase_chans[p-1]);
          write_reg(REG_TAPS, phase_taps[p-1]);
        end
      end
      settings_used++;
      calm = (p == 4);
      if (p == 8) hold_go = 1'b1;
      n_ch = chans_now();
      n_items = (n_ch > 64) ? 40 : 180;
      for (int unsigned i = 0; i < n_items; i++) begin
        r = '0;
        r.kind = ($urandom_range(99) < 12) ? KIND_WEIGHT : KIND_SAMPLE;
        r.wch = ($urandom_range(3) == 0) ? CH_FIELD_W'($urandom)
                                         : CH_FIELD_W'($urandom_range(n_ch - 1));
        r.wtap = TAP_FIELD_W'($urandom);
        r.wval = $urandom_range(1) ? DATA_W'($urandom) : DATA_W'($urandom_range(32767) - 16384);
        r.gb = $urandom_range(2) ? DATA_W'($urandom_range(16383) - 8192) : DATA_W'($urandom);
        r.gc = $urandom_range(2) ? DATA_W'($urandom_range(16383) - 8192) : DATA_W'($urandom);
        r.x = $urandom_range(2) ? DATA_W'($urandom_range(32767) - 16384) : DATA_W'($urandom);
        offer_item(r);
      end
    end
    wait_for_results();

    $display("Checked %0d results from %0d samples and %0d weight writes over %0d settings.",
             results_seen, samples_sent, weights_sent, settings_used);
    $display("%0d results carried the saturation flag and %0d closed a time step.",
             sat_seen, ends_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/gdcc_pkg.sv
sv/gdcc_ram.sv
sv/gated_depthwise_causal_conv.sv
sv/gdcc_checker.sv
test/gated_depthwise_causal_conv_test.sv
